FILE: rtl/ptc_pkg.sv
`default_nettype none
package ptc_pkg;

	// Calibration register indexes on the configuration port
	typedef enum logic [2:0] {
		CFG_SENS        = 3'd0,
		CFG_OFFSET      = 3'd1,
		CFG_SENS_TEMP   = 3'd2,
		CFG_OFFSET_TEMP = 3'd3,
		CFG_REF_TEMP    = 3'd4,
		CFG_TEMP_SENS   = 3'd5
	} cfg_idx_t;

	localparam int unsigned CoefWidth = 16;
	localparam int unsigned RawWidth  = 24;

	// Output temperature limits (18-bit signed) and base offset
	localparam logic signed [19:0] TempBase = 20'sd2000;
	localparam logic signed [19:0] TempMax  = 20'sd131071;
	localparam logic signed [19:0] TempMin  = -20'sd131072;

	// Pressure limits (32-bit signed), checked at 33 bits
	localparam logic signed [32:0] PressMax = 33'sd2147483647;
	localparam logic signed [32:0] PressMin = -33'sd2147483648;

	// Calibration words C1..C6
	typedef struct packed {
		logic [CoefWidth-1:0] sens;         // C1
		logic [CoefWidth-1:0] offset;       // C2
		logic [CoefWidth-1:0] sens_temp;    // C3
		logic [CoefWidth-1:0] offset_temp;  // C4
		logic [CoefWidth-1:0] ref_temp;     // C5
		logic [CoefWidth-1:0] temp_sens;    // C6
	} coef_t;

	// Intermediate terms handed from the temperature front end to the pressure back end
	typedef struct packed {
		logic [RawWidth-1:0] d1;
		logic signed [17:0]  temp;
		logic signed [35:0]  off;
		logic signed [34:0]  sens;
	} comp_res_t;

endpackage
`default_nettype wire

FILE: rtl/ptc_cfg_regs.sv
`default_nettype none
module ptc_cfg_regs
	import ptc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [CoefWidth-1:0] cfg_data,
	output coef_t                     coef
);

	coef_t coef_q;

	// Calibration register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SENS:        coef_q.sens        <= cfg_data;
				CFG_OFFSET:      coef_q.offset      <= cfg_data;
				CFG_SENS_TEMP:   coef_q.sens_temp   <= cfg_data;
				CFG_OFFSET_TEMP: coef_q.offset_temp <= cfg_data;
				CFG_REF_TEMP:    coef_q.ref_temp    <= cfg_data;
				CFG_TEMP_SENS:   coef_q.temp_sens   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign coef = coef_q;

endmodule
`default_nettype wire

FILE: rtl/ptc_temp_front.sv
`default_nettype none
module ptc_temp_front
	import ptc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire coef_t               coef,
	input  wire logic                in_valid,
	input  wire logic [RawWidth-1:0] raw_pressure,
	input  wire logic [RawWidth-1:0] raw_temperature,
	output logic                     res_valid,
	output comp_res_t                res
);

	logic                valid_s1, valid_s2, valid_s3;
	logic [RawWidth-1:0] d1_s1, d1_s2;
	logic signed [24:0]  dt_s1;
	logic signed [41:0]  prod_t_s2, prod_off_s2, prod_sens_s2;
	comp_res_t           res_s3;

	logic signed [24:0] dt_c;
	logic signed [41:0] dt_x, c6_x, c4_x, c3_x;
	logic signed [41:0] t_b, off_b, sens_b;
	logic signed [18:0] t_div;
	logic signed [19:0] t_full;
	logic signed [34:0] off_div;
	logic signed [33:0] sens_div;
	comp_res_t          res_c;

	// Stage 1: dT = D2 - C5*256
	always_comb begin
		dt_c = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.ref_temp, 8'h00});
	end

	// Stage 2 operands: dT against C6, C4 and C3
	always_comb begin
		dt_x = {{17{dt_s1[24]}}, dt_s1};
		c6_x = {26'b0, coef.temp_sens};
		c4_x = {26'b0, coef.offset_temp};
		c3_x = {26'b0, coef.sens_temp};
	end

	// Stage 3: truncating shifts, TEMP with clamp, OFF and SENS
	always_comb begin
		t_b    = prod_t_s2 + (prod_t_s2[41] ? 42'sd8388607 : 42'sd0);
		t_div  = t_b[41:23];
		t_full = {t_div[18], t_div} + TempBase;
		off_b  = prod_off_s2 + (prod_off_s2[41] ? 42'sd127 : 42'sd0);
		off_div = off_b[41:7];
		sens_b = prod_sens_s2 + (prod_sens_s2[41] ? 42'sd255 : 42'sd0);
		sens_div = sens_b[41:8];

		res_c.d1 = d1_s2;
		if (t_full > TempMax) begin
			res_c.temp = TempMax[17:0];
		end else if (t_full < TempMin) begin
			res_c.temp = TempMin[17:0];
		end else begin
			res_c.temp = t_full[17:0];
		end
		res_c.off  = $signed({4'b0, coef.offset, 16'h0000}) + {off_div[34], off_div};
		res_c.sens = $signed({4'b0, coef.sens, 15'h0000}) + {sens_div[33], sens_div};
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (advance) begin
			d1_s1        <= raw_pressure;
			dt_s1        <= dt_c;
			d1_s2        <= d1_s1;
			prod_t_s2    <= dt_x * c6_x;
			prod_off_s2  <= dt_x * c4_x;
			prod_sens_s2 <= dt_x * c3_x;
			res_s3       <= res_c;
		end
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;

endmodule
`default_nettype wire

FILE: rtl/ptc_press_back.sv
`default_nettype none
module ptc_press_back
	import ptc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         advance,
	input  wire logic         res_valid,
	input  wire comp_res_t    res,
	output logic              out_valid,
	output logic signed [17:0] temperature_centi_c,
	output logic signed [31:0] pressure_tenth_mbar,
	output logic              pressure_saturated
);

	logic               valid_s4, valid_s5, valid_s6, valid_s7;
	logic [40:0]        pp_lo_s4;
	logic signed [42:0] pp_hi_s4;
	logic signed [35:0] off_s4, off_s5;
	logic signed [17:0] temp_s4, temp_s5, temp_s6, temp_s7;
	logic signed [60:0] prod_s5;
	logic signed [40:0] diff_s6;
	logic signed [31:0] press_s7;
	logic               sat_s7;

	logic [40:0]        lo_a, lo_b;
	logic signed [42:0] hi_a, hi_b;
	logic signed [60:0] prod_c, q_b;
	logic signed [39:0] q;
	logic signed [40:0] diff_c, p_b;
	logic signed [27:0] p;
	logic signed [32:0] p_x;

	// Stage 4: D1*SENS split into two partial products on 17-bit boundary
	always_comb begin
		lo_a = {17'b0, res.d1};
		lo_b = {24'b0, res.sens[16:0]};
		hi_a = {19'b0, res.d1};
		hi_b = {{25{res.sens[34]}}, res.sens[34:17]};
	end

	// Stage 5: recombine partial products
	always_comb begin
		prod_c = {pp_hi_s4[42], pp_hi_s4, 17'b0} + {20'b0, pp_lo_s4};
	end

	// Stage 6: truncate by 2^21, subtract OFF
	always_comb begin
		q_b    = prod_s5 + (prod_s5[60] ? 61'sd2097151 : 61'sd0);
		q      = q_b[60:21];
		diff_c = {q[39], q} - {{5{off_s5[35]}}, off_s5};
	end

	// Stage 7: truncate by 2^13, clamp to 32-bit signed
	always_comb begin
		p_b = diff_s6 + (diff_s6[40] ? 41'sd8191 : 41'sd0);
		p   = p_b[40:13];
		p_x = {{5{p[27]}}, p};
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= res_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (advance) begin
			pp_lo_s4 <= lo_a * lo_b;
			pp_hi_s4 <= hi_a * hi_b;
			off_s4   <= res.off;
			temp_s4  <= res.temp;
			prod_s5  <= prod_c;
			off_s5   <= off_s4;
			temp_s5  <= temp_s4;
			diff_s6  <= diff_c;
			temp_s6  <= temp_s5;
			temp_s7  <= temp_s6;
			if (p_x > PressMax) begin
				press_s7 <= PressMax[31:0];
				sat_s7   <= 1'b1;
			end else if (p_x < PressMin) begin
				press_s7 <= PressMin[31:0];
				sat_s7   <= 1'b1;
			end else begin
				press_s7 <= p_x[31:0];
				sat_s7   <= 1'b0;
			end
		end
	end

	assign out_valid           = valid_s7;
	assign temperature_centi_c = temp_s7;
	assign pressure_tenth_mbar = press_s7;
	assign pressure_saturated  = sat_s7;

endmodule
`default_nettype wire

FILE: rtl/pressure_temp_compensation_core.sv
// First-order pressure/temperature compensation for a 24-bit barometric
// sensor: each input transaction (raw pressure D1, raw temperature D2)
// yields one output transaction with temperature in 0.01 degC and pressure
// in 0.1 mbar, computed from the six calibration words C1..C6 written on
// the configuration port (indexes 0..5, reset 0, write only while idle).
// The datapath is a seven-stage pipeline: one transaction enters per
// cycle while the pipeline is not stalled. Throughput is one transaction
// per clock when not stalled, set by the fully pipelined multipliers (the
// D1*SENS product is split into two partial products over two stages).
// A stall on the output while a result is valid freezes the whole pipeline
// and is passed straight back as in_stall.
`default_nettype none
module pressure_temp_compensation_core
	import ptc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [CoefWidth-1:0] cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [RawWidth-1:0]  raw_pressure,
	input  wire logic [RawWidth-1:0]  raw_temperature,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [17:0]        temperature_centi_c,
	output logic signed [31:0]        pressure_tenth_mbar,
	output logic                      pressure_saturated
);

	coef_t     coef;
	comp_res_t mid_res;
	logic      mid_valid;
	logic      advance;

	// Global pipeline enable: hold everything while the result waits
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	ptc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	ptc_temp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.coef            (coef),
		.in_valid        (in_valid),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.res_valid       (mid_valid),
		.res             (mid_res)
	);

	ptc_press_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.advance             (advance),
		.res_valid           (mid_valid),
		.res                 (mid_res),
		.out_valid           (out_valid),
		.temperature_centi_c (temperature_centi_c),
		.pressure_tenth_mbar (pressure_tenth_mbar),
		.pressure_saturated  (pressure_saturated)
	);

`ifndef SYNTHESIS
	// Saturation flag only with a clamped pressure value
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressure_saturated |->
			pressure_tenth_mbar == 32'sh7FFFFFFF || pressure_tenth_mbar == 32'sh80000000)
		else $error("saturation flag without clamped pressure");

	// Mid-pipeline valid holds while frozen
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(mid_valid))
		else $error("pipeline moved during stall");

	// Temperature output stays at or below the upper clamp limit
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centi_c <= 18'sd131071)
		else $error("temperature out of range");
`endif

endmodule
`default_nettype wire
